// ----- hw/rtl/chte_pkg.sv -----
// Package: shared types and constants of the chained hash table engine.
package chte_pkg;

    localparam int OP_W      = 3;
    localparam int KEY_W     = 64;
    localparam int LEN_W     = 4;
    localparam int ITEM_W    = 32;
    localparam int TOT_W     = 6;
    localparam int CFG_W     = 5;
    localparam int HASH_W    = 32;
    localparam int HASH_SHL  = 5;
    localparam int RESET_BKT = 16;
    localparam int NUM_BUCKETS = 16;
    localparam int ENTRIES     = 32;
    localparam logic [HASH_W-1:0] HASH_SEED = 32'd1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_GET    = 3'd1,
        OP_REMOVE = 3'd2,
        OP_LIST   = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HASH,
        ST_FREE,
        ST_S_RK,
        ST_S_SL,
        ST_S_CHK,
        ST_SH_RD,
        ST_SH_WR,
        ST_L_RK,
        ST_L_SL,
        ST_L_CHK,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_HASH,
        BK_DIV
    } t_bkt_state;

endpackage

// ----- hw/rtl/chte_if.sv -----
// Interfaces: request and response channels of the hash table engine.
interface chte_req_if;
    import chte_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  key_len;
    logic [ITEM_W-1:0] item;

    modport source (output valid, operation, key, key_len, item, input ready);
    modport sink   (input valid, operation, key, key_len, item, output ready);
endinterface

interface chte_rsp_if;
    import chte_pkg::*;
    logic              valid;
    logic              ready;
    logic              found;
    logic [ITEM_W-1:0] item_out;
    logic [TOT_W-1:0]  entry_total;
    logic              empty_res;
    logic              full_error;
    logic              last;

    modport source (output valid, found, item_out, entry_total, empty_res, full_error,
                    last, input ready);
    modport sink   (input valid, found, item_out, entry_total, empty_res, full_error,
                    last, output ready);
endinterface

// ----- hw/rtl/chte_bucket.sv -----
// Bucket unit: byte-serial hash followed by a bit-serial restoring modulo.
module chte_bucket import chte_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KEY_W-1:0] i_key,
    input  logic [LEN_W-1:0] i_len,
    input  logic [CFG_W-1:0] i_div,
    output logic             o_done,
    output logic [CFG_W-1:0] o_bucket
);
    localparam int CNT_W = $clog2(HASH_W);

    t_bkt_state          r_state, n_state;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [LEN_W-1:0]    r_left, n_left;
    logic [HASH_W-1:0]   r_h, n_h;
    logic [CFG_W:0]      r_rem, n_rem;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [CFG_W-1:0]    r_div, n_div;
    logic [CFG_W:0]      rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_key  <= n_key;
        r_left <= n_left;
        r_h    <= n_h;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_div  <= n_div;
    end

    always_comb begin
        n_state = r_state;
        n_key   = r_key;
        n_left  = r_left;
        n_h     = r_h;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_div   = r_div;
        o_done  = 1'b0;
        rem_sh  = {r_rem[CFG_W-1:0], r_h[HASH_W-1]};
        case (r_state)
            BK_IDLE: begin
                if (i_start) begin
                    n_key   = i_key;
                    n_left  = i_len;
                    n_h     = HASH_SEED;
                    n_div   = i_div;
                    n_state = BK_HASH;
                end
            end
            BK_HASH: begin
                if (r_left == '0) begin
                    // wrap-around add of the divisor, then reduce
                    n_h     = r_h + HASH_W'(r_div);
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = BK_DIV;
                end else begin
                    n_h    = (r_h << HASH_SHL) ^ HASH_W'(r_key[7:0]) ^ r_h;
                    n_key  = r_key >> 8;
                    n_left = r_left - 1'b1;
                end
            end
            BK_DIV: begin
                if (rem_sh >= {1'b0, r_div}) begin
                    n_rem = rem_sh - {1'b0, r_div};
                end else begin
                    n_rem = rem_sh;
                end
                n_h   = r_h << 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(HASH_W - 1)) begin
                    n_state = BK_IDLE;
                    o_done  = 1'b1;
                end
            end
            default: n_state = BK_IDLE;
        endcase
        o_bucket = n_rem[CFG_W-1:0];
    end
endmodule

// ----- hw/rtl/chained_hash_table_engine.sv -----
// Top level: chained hash table engine with sequenced hash, search and list.
// The engine takes one transaction at a time and drops i_req.ready while it
// works on it; a finished response may still wait in the output register
// while the next transaction is taken. Add, get and remove first run the
// bucket unit: a byte-serial hash of the key, the bucket-count add and the
// 32-step modulo.
// Add then scans the valid bits for a free slot.
// Get and remove walk the stored entries oldest first through a rank table,
// reading rank, then slot, then checking, over the two memory read ports;
// remove then closes the gap in the rank table, one read and one write per
// later entry. List all walks the buckets in order against every stored
// rank until the last stored entry is sent; a matching entry waits while the
// output register is full. Clear is answered straight from the emit state.
// No reset sweep is used: only the valid bits and the entry count are cleared.
module chained_hash_table_engine import chte_pkg::*; #(
    parameter int KEY_BYTES   = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    chte_req_if.sink         i_req,
    chte_rsp_if.source       o_rsp
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

    // slot storage, all at one address per slot
    logic [KEY_W-1:0]  slot_key_mem  [ENTRIES];
    logic [LEN_W-1:0]  slot_len_mem  [ENTRIES];
    logic [ITEM_W-1:0] slot_item_mem [ENTRIES];
    logic [BW-1:0]     slot_bkt_mem  [ENTRIES];
    // rank table: insertion rank -> slot
    logic [IW-1:0]     rank_mem      [ENTRIES];

    logic [KEY_W-1:0]  r_key_q;
    logic [LEN_W-1:0]  r_len_q;
    logic [ITEM_W-1:0] r_item_q;
    logic [BW-1:0]     r_bkt_q;
    logic [IW-1:0]     r_rank_q;

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_cfg;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [CW-1:0]     r_total, n_total;
    t_op               r_op, n_op;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [ITEM_W-1:0] r_item, n_item;
    logic [BW-1:0]     r_bkt, n_bkt;
    logic [IW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_rank, n_rank;
    logic [IW-1:0]     r_slot, n_slot;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_res_found, n_res_found;
    logic [ITEM_W-1:0] r_res_item, n_res_item;
    logic              r_res_full, n_res_full;

    logic              r_out_valid, n_out_valid;
    logic              r_out_found, n_out_found;
    logic [ITEM_W-1:0] r_out_item, n_out_item;
    logic [CW-1:0]     r_out_total, n_out_total;
    logic              r_out_full, n_out_full;
    logic              r_out_last, n_out_last;

    logic              can_emit;
    logic [CFG_W-1:0]  eff_div;
    logic [LEN_W-1:0]  in_len;
    logic [KEY_W-1:0]  in_key;
    logic              bk_start, bk_done;
    logic [CFG_W-1:0]  bk_bucket;
    logic              slot_we, rank_we;
    logic [IW-1:0]     rank_waddr, rank_wdata, rank_raddr, slot_raddr;

    // effective bucket count: zero acts as one, saturate at NUM_BUCKETS
    always_comb begin
        if (r_cfg == '0) begin
            eff_div = CFG_W'(1);
        end else if (int'(r_cfg) > NUM_BUCKETS) begin
            eff_div = CFG_W'(NUM_BUCKETS);
        end else begin
            eff_div = r_cfg;
        end
    end

    // saturate the length and zero the key bytes beyond it
    always_comb begin
        if (int'(i_req.key_len) > KEY_BYTES) begin
            in_len = LEN_W'(KEY_BYTES);
        end else begin
            in_len = i_req.key_len;
        end
        for (int b = 0; b < KEY_W / 8; b++) begin
            in_key[8*b +: 8] = (b < int'(in_len)) ? i_req.key[8*b +: 8] : 8'h00;
        end
    end

    chte_bucket u_bucket (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (bk_start),
        .i_key    (r_key),
        .i_len    (r_len),
        .i_div    (eff_div),
        .o_done   (bk_done),
        .o_bucket (bk_bucket)
    );

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_key_mem[r_idx]  <= r_key;
            slot_len_mem[r_idx]  <= r_len;
            slot_item_mem[r_idx] <= r_item;
            slot_bkt_mem[r_idx]  <= r_bkt;
        end
        r_key_q  <= slot_key_mem[slot_raddr];
        r_len_q  <= slot_len_mem[slot_raddr];
        r_item_q <= slot_item_mem[slot_raddr];
        r_bkt_q  <= slot_bkt_mem[slot_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (rank_we) begin
            rank_mem[rank_waddr] <= rank_wdata;
        end
        r_rank_q <= rank_mem[rank_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg       <= CFG_W'(RESET_BKT);
            r_valid     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            r_valid     <= n_valid;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
        r_op        <= n_op;
        r_key       <= n_key;
        r_len       <= n_len;
        r_item      <= n_item;
        r_bkt       <= n_bkt;
        r_idx       <= n_idx;
        r_rank      <= n_rank;
        r_slot      <= n_slot;
        r_cnt       <= n_cnt;
        r_res_found <= n_res_found;
        r_res_item  <= n_res_item;
        r_res_full  <= n_res_full;
        r_out_found <= n_out_found;
        r_out_item  <= n_out_item;
        r_out_total <= n_out_total;
        r_out_full  <= n_out_full;
        r_out_last  <= n_out_last;
    end

    assign can_emit = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_total     = r_total;
        n_op        = r_op;
        n_key       = r_key;
        n_len       = r_len;
        n_item      = r_item;
        n_bkt       = r_bkt;
        n_idx       = r_idx;
        n_rank      = r_rank;
        n_slot      = r_slot;
        n_cnt       = r_cnt;
        n_res_found = r_res_found;
        n_res_item  = r_res_item;
        n_res_full  = r_res_full;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_found = r_out_found;
        n_out_item  = r_out_item;
        n_out_total = r_out_total;
        n_out_full  = r_out_full;
        n_out_last  = r_out_last;
        i_req.ready = 1'b0;
        bk_start    = 1'b0;
        slot_we     = 1'b0;
        rank_we     = 1'b0;
        rank_waddr  = r_rank[IW-1:0];
        rank_wdata  = r_rank_q;
        rank_raddr  = r_rank[IW-1:0];
        slot_raddr  = r_rank_q;

        case (r_state)
            ST_IDLE: begin
                // nothing is taken while reset is held
                i_req.ready = i_rst_n;
                n_res_found = 1'b0;
                n_res_item  = '0;
                n_res_full  = 1'b0;
                if (i_req.valid) begin
                    n_op   = t_op'(i_req.operation);
                    n_key  = in_key;
                    n_len  = in_len;
                    n_item = i_req.item;
                    n_rank = '0;
                    n_idx  = '0;
                    n_cnt  = '0;
                    n_bkt  = '0;
                    case (t_op'(i_req.operation))
                        OP_ADD: begin
                            if (r_total == CW'(ENTRIES)) begin
                                n_res_full = 1'b1;
                                n_state    = ST_EMIT;
                            end else begin
                                n_state = ST_HASH;
                            end
                        end
                        OP_GET, OP_REMOVE: n_state = ST_HASH;
                        OP_LIST: begin
                            n_state = (r_total == '0) ? ST_EMIT : ST_L_RK;
                        end
                        OP_CLEAR: begin
                            n_valid = '0;
                            n_total = '0;
                            n_state = ST_EMIT;
                        end
                        default: n_state = ST_EMIT;
                    endcase
                end
            end
            ST_HASH: begin
                // bucket unit is started on the first cycle here
                bk_start = (r_cnt == '0);
                n_cnt    = CW'(1);
                if (bk_done) begin
                    n_bkt   = BW'(bk_bucket);
                    n_state = (r_op == OP_ADD) ? ST_FREE : ST_S_RK;
                end
            end
            ST_FREE: begin
                if (!r_valid[r_idx]) begin
                    slot_we           = 1'b1;
                    rank_we           = 1'b1;
                    rank_waddr        = r_total[IW-1:0];
                    rank_wdata        = r_idx;
                    n_valid[r_idx]    = 1'b1;
                    n_total           = r_total + 1'b1;
                    n_state           = ST_EMIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_S_RK: begin
                if (r_rank == r_total) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_S_SL;
                end
            end
            ST_S_SL: begin
                n_slot  = r_rank_q;
                n_state = ST_S_CHK;
            end
            ST_S_CHK: begin
                if (r_bkt_q == r_bkt && r_len_q == r_len && r_key_q == r_key) begin
                    n_res_found = 1'b1;
                    n_res_item  = r_item_q;
                    if (r_op == OP_REMOVE) begin
                        n_valid[r_slot] = 1'b0;
                        n_state         = ST_SH_RD;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end else begin
                    n_rank  = r_rank + 1'b1;
                    n_state = ST_S_RK;
                end
            end
            ST_SH_RD: begin
                // close the gap in the rank table left by the removed entry
                rank_raddr = IW'(r_rank + 1'b1);
                if (r_rank + 1'b1 == r_total) begin
                    n_total = r_total - 1'b1;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_SH_WR;
                end
            end
            ST_SH_WR: begin
                rank_we = 1'b1;
                n_rank  = r_rank + 1'b1;
                n_state = ST_SH_RD;
            end
            ST_L_RK: begin
                n_state = ST_L_SL;
            end
            ST_L_SL: begin
                n_state = ST_L_CHK;
            end
            ST_L_CHK: begin
                if (r_bkt_q != r_bkt || can_emit) begin
                    if (r_bkt_q == r_bkt) begin
                        n_out_valid = 1'b1;
                        n_out_found = 1'b1;
                        n_out_item  = r_item_q;
                        n_out_total = r_total;
                        n_out_full  = 1'b0;
                        n_out_last  = (r_cnt + 1'b1 == r_total);
                        n_cnt       = r_cnt + 1'b1;
                    end
                    if (r_bkt_q == r_bkt && r_cnt + 1'b1 == r_total) begin
                        n_state = ST_IDLE;
                    end else if (r_rank + 1'b1 == r_total) begin
                        n_rank  = '0;
                        n_bkt   = r_bkt + 1'b1;
                        n_state = ST_L_RK;
                    end else begin
                        n_rank  = r_rank + 1'b1;
                        n_state = ST_L_RK;
                    end
                end
            end
            ST_EMIT: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_res_found;
                    n_out_item  = r_res_item;
                    n_out_total = r_total;
                    n_out_full  = r_res_full;
                    n_out_last  = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.item_out    = r_out_item;
    assign o_rsp.entry_total = TOT_W'(r_out_total);
    assign o_rsp.empty_res   = (r_out_total == '0);
    assign o_rsp.full_error  = r_out_full;
    assign o_rsp.last        = r_out_last;

endmodule

// ----- verif/chte_tb_if.sv -----
// Testbench package: request and response transaction structs.
package chte_tb_pkg;
    import chte_pkg::*;

    typedef struct packed {
        logic              found;
        logic [ITEM_W-1:0] item_out;
        logic [TOT_W-1:0]  entry_total;
        logic              empty_res;
        logic              full_error;
        logic              last;
    } t_rsp;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  key_len;
        logic [ITEM_W-1:0] item;
    } t_req;
endpackage

// ----- verif/chained_hash_table_engine_tb.sv -----
// Testbench: self-checking stimulus and prediction for the chained hash table engine.
module chained_hash_table_engine_tb;
    import chte_pkg::*;
    import chte_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBKT      = 16;
    localparam int NSLOT     = 32;
    localparam int MAX_CYC   = 2000000;
    localparam int DRAIN_CYC = 3000;
    localparam int LONG_HOLD = 4000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    chte_req_if req_ch();
    chte_rsp_if rsp_ch();

    chained_hash_table_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch.sink),
        .o_rsp       (rsp_ch.source)
    );

    // Shadow copy of the table, kept in step with accepted transactions.
    logic [KEY_W-1:0]  tbl_key   [NSLOT];
    logic [LEN_W-1:0]  tbl_len   [NSLOT];
    logic [ITEM_W-1:0] tbl_item  [NSLOT];
    logic [3:0]        tbl_bkt   [NSLOT];
    int unsigned       tbl_rank  [NSLOT];
    logic              tbl_used  [NSLOT];
    int unsigned       tbl_count;
    logic [CFG_W-1:0]  bkt_cfg;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   fail_count;
    longint cycle_count;
    bit   hold_rsp;       // forces a long receiver stall
    bit   stim_done;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [3:0] bucket_for(logic [KEY_W-1:0] k, int unsigned len);
        logic [31:0] h;
        int unsigned b;
        h = HASH_SEED;
        b = (bkt_cfg == 0) ? 1 : (bkt_cfg > NBKT ? NBKT : bkt_cfg);
        for (int i = 0; i < len; i++)
            h = (h << HASH_SHL) ^ {24'd0, k[8*i +: 8]} ^ h;
        h = h + b;
        return 4'(h % b);
    endfunction

    function automatic t_rsp status_rsp(logic fnd, logic [ITEM_W-1:0] it, logic full,
                                        logic lst);
        t_rsp r;
        r.found       = fnd;
        r.item_out    = it;
        r.entry_total = TOT_W'(tbl_count);
        r.empty_res   = (tbl_count == 0);
        r.full_error  = full;
        r.last        = lst;
        return r;
    endfunction

    // Apply one accepted transaction to the shadow table, queue its responses.
    task automatic predict_table_op(t_req rq);
        int unsigned len;
        logic [KEY_W-1:0] k;
        logic [3:0] b;
        int hit, n;
        len = (rq.key_len > 8) ? 8 : rq.key_len;
        k = (len >= 8) ? rq.key : (rq.key & ((64'd1 << (8*len)) - 64'd1));
        hit = -1;
        case (rq.operation)
            OP_ADD: begin
                for (int s = 0; s < NSLOT; s++)
                    if (!tbl_used[s] && hit < 0) hit = s;
                if (hit < 0) begin
                    expected_rsps.push_back(status_rsp(0, 0, 1, 1));
                end else begin
                    tbl_key[hit] = k; tbl_len[hit] = LEN_W'(len); tbl_item[hit] = rq.item;
                    tbl_bkt[hit] = bucket_for(k, len); tbl_rank[hit] = tbl_count;
                    tbl_used[hit] = 1; tbl_count++;
                    expected_rsps.push_back(status_rsp(0, 0, 0, 1));
                end
            end
            OP_GET, OP_REMOVE: begin
                b = bucket_for(k, len);
                for (int s = 0; s < NSLOT; s++)
                    if (tbl_used[s] && tbl_bkt[s] == b && tbl_len[s] == len &&
                        tbl_key[s] == k && (hit < 0 || tbl_rank[s] < tbl_rank[hit]))
                        hit = s;
                if (hit < 0) begin
                    expected_rsps.push_back(status_rsp(0, 0, 0, 1));
                end else begin
                    if (rq.operation == OP_REMOVE) begin
                        tbl_used[hit] = 0;
                        for (int s = 0; s < NSLOT; s++)
                            if (tbl_used[s] && tbl_rank[s] > tbl_rank[hit]) tbl_rank[s]--;
                        tbl_count--;
                    end
                    expected_rsps.push_back(status_rsp(1, tbl_item[hit], 0, 1));
                end
            end
            OP_LIST: begin
                if (tbl_count == 0) begin
                    expected_rsps.push_back(status_rsp(0, 0, 0, 1));
                end else begin
                    n = 0;
                    // bucket order first, then insertion order inside a bucket
                    for (int bb = 0; bb < NBKT; bb++)
                        for (int r = 0; r < tbl_count; r++)
                            for (int s = 0; s < NSLOT; s++)
                                if (tbl_used[s] && tbl_bkt[s] == bb && tbl_rank[s] == r) begin
                                    n++;
                                    expected_rsps.push_back(status_rsp(1, tbl_item[s], 0,
                                                                       n == tbl_count));
                                end
                end
            end
            OP_CLEAR: begin
                for (int s = 0; s < NSLOT; s++) tbl_used[s] = 0;
                tbl_count = 0;
                expected_rsps.push_back(status_rsp(0, 0, 0, 1));
            end
            default: expected_rsps.push_back(status_rsp(0, 0, 0, 1));
        endcase
    endtask

    // Driver: one transaction at a time from pending_reqs, random gap before each.
    int send_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            send_gap     <= $urandom_range(0, 17);
        end else if (req_ch.valid && req_ch.ready) begin
            predict_table_op(pending_reqs.pop_front());
            req_ch.valid <= 1'b0;
            send_gap     <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        end else if (!req_ch.valid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_reqs.size() > 0) begin
                req_ch.valid      <= 1'b1;
                req_ch.operation  <= pending_reqs[0].operation;
                req_ch.key        <= pending_reqs[0].key;
                req_ch.key_len    <= pending_reqs[0].key_len;
                req_ch.item       <= pending_reqs[0].item;
            end
        end
    end

    // Monitor: random stalls on the response side, field-by-field compare.
    int stall_left;
    int hold_left;
    t_rsp exp_r;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
            hold_left    <= 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("unexpected response item_out=%h", rsp_ch.item_out);
                    fail_count++;
                end else begin
                    exp_r = expected_rsps.pop_front();
                    if (rsp_ch.found !== exp_r.found) begin
                        $error("found exp %0d got %0d", exp_r.found, rsp_ch.found); fail_count++;
                    end
                    if (rsp_ch.item_out !== exp_r.item_out) begin
                        $error("item_out exp %h got %h", exp_r.item_out, rsp_ch.item_out);
                        fail_count++;
                    end
                    if (rsp_ch.entry_total !== exp_r.entry_total) begin
                        $error("entry_total exp %0d got %0d", exp_r.entry_total,
                               rsp_ch.entry_total);
                        fail_count++;
                    end
                    if (rsp_ch.empty_res !== exp_r.empty_res) begin
                        $error("empty_res exp %0d got %0d", exp_r.empty_res, rsp_ch.empty_res);
                        fail_count++;
                    end
                    if (rsp_ch.full_error !== exp_r.full_error) begin
                        $error("full_error exp %0d got %0d", exp_r.full_error,
                               rsp_ch.full_error);
                        fail_count++;
                    end
                    if (rsp_ch.last !== exp_r.last) begin
                        $error("last exp %0d got %0d", exp_r.last, rsp_ch.last); fail_count++;
                    end
                end
            end
            // long hold-off counted here while the driver keeps offering
            if (hold_rsp && hold_left == 0 && rsp_ch.ready) begin
                rsp_ch.ready <= 1'b0;
                hold_left    <= LONG_HOLD;
            end else if (hold_left > 1) begin
                hold_left <= hold_left - 1;
            end else if (hold_left == 1) begin
                hold_left <= 0;
                hold_rsp  <= 1'b0;
                rsp_ch.ready <= 1'b1;
            end else if (rsp_ch.valid && rsp_ch.ready) begin
                stall_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
                rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            end else if (!rsp_ch.ready) begin
                if (stall_left > 0) stall_left <= stall_left - 1;
                else rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > MAX_CYC) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic t_req make_req(t_op op, logic [KEY_W-1:0] k, logic [LEN_W-1:0] l,
                                      logic [ITEM_W-1:0] it);
        t_req r;
        r.operation = op; r.key = k; r.key_len = l; r.item = it;
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    // Wait until every queued transaction went out and every response came back.
    task automatic wait_idle();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_buckets(logic [CFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        bkt_cfg = v;
    endtask

    // Random phase: a small key pool so get/remove hit often.
    task automatic random_phase(int n);
        logic [KEY_W-1:0] pool_key [6];
        logic [LEN_W-1:0] pool_len [6];
        int p, sel;
        for (int i = 0; i < 6; i++) begin
            pool_key[i] = rand_key();
            pool_len[i] = $urandom_range(0, 8);
        end
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(0, 5);
            sel = $urandom_range(0, 99);
            if (sel < 40)
                pending_reqs.push_back(make_req(OP_ADD, pool_key[p], pool_len[p], $urandom()));
            else if (sel < 60)
                pending_reqs.push_back(make_req(OP_GET, pool_key[p], pool_len[p], $urandom()));
            else if (sel < 78)
                pending_reqs.push_back(make_req(OP_REMOVE, pool_key[p], pool_len[p],
                                                $urandom()));
            else if (sel < 86)
                pending_reqs.push_back(make_req(OP_LIST, rand_key(), $urandom_range(0, 15),
                                                $urandom()));
            else if (sel < 89)
                pending_reqs.push_back(make_req(OP_CLEAR, rand_key(), $urandom_range(0, 15),
                                                $urandom()));
            else if (sel < 92)
                pending_reqs.push_back(make_req(t_op'($urandom_range(5, 7)), rand_key(),
                                                $urandom_range(0, 15), $urandom()));
            else
                pending_reqs.push_back(make_req(t_op'($urandom_range(0, 2)), rand_key(),
                                                $urandom_range(0, 15), $urandom()));
        end
    endtask

    initial begin
        fail_count   = 0;
        cycle_count  = 0;
        hold_rsp     = 1'b0;
        tbl_count    = 0;
        bkt_cfg      = RESET_BKT;
        for (int s = 0; s < NSLOT; s++) tbl_used[s] = 0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        req_ch.valid = 1'b0;
        req_ch.operation = '0; req_ch.key = '0; req_ch.key_len = '0; req_ch.item = '0;
        rsp_ch.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table cases, extremes, duplicates, oversized lengths.
        pending_reqs.push_back(make_req(OP_LIST, '0, 0, 0));
        pending_reqs.push_back(make_req(OP_GET, '1, 8, 0));
        pending_reqs.push_back(make_req(OP_REMOVE, '1, 8, 0));
        pending_reqs.push_back(make_req(OP_ADD, '0, 0, '1));
        pending_reqs.push_back(make_req(OP_ADD, '1, 8, 32'h1234_5678));
        pending_reqs.push_back(make_req(OP_ADD, '1, 15, 32'hAAAA_5555));  // dup after saturation
        pending_reqs.push_back(make_req(OP_ADD, 64'hFFFF_FFFF_FF00_00AB, 1, 32'h5555_AAAA));
        pending_reqs.push_back(make_req(OP_GET, 64'h0000_0000_0000_00AB, 1, 0));
        pending_reqs.push_back(make_req(OP_GET, '1, 8, 0));
        pending_reqs.push_back(make_req(OP_REMOVE, '1, 9, 0));
        pending_reqs.push_back(make_req(OP_GET, '1, 8, 0));
        pending_reqs.push_back(make_req(OP_GET, 64'h55, 0, 0));
        pending_reqs.push_back(make_req(OP_LIST, '0, 0, 0));
        pending_reqs.push_back(make_req(t_op'(3'd5), '1, 4, '1));
        pending_reqs.push_back(make_req(t_op'(3'd7), '0, 0, 0));
        pending_reqs.push_back(make_req(OP_CLEAR, '0, 0, 0));
        pending_reqs.push_back(make_req(OP_LIST, '0, 0, 0));
        wait_idle();

        // Fill past capacity with the responses held off: input must back up.
        hold_rsp = 1'b1;
        for (int i = 0; i < NSLOT + 2; i++)
            pending_reqs.push_back(make_req(OP_ADD, rand_key(), $urandom_range(0, 8),
                                            $urandom()));
        pending_reqs.push_back(make_req(OP_LIST, '0, 0, 0));
        pending_reqs.push_back(make_req(OP_CLEAR, '0, 0, 0));
        wait_idle();

        // Random phases across bucket counts, extremes included.
        write_buckets(5'd1);
        random_phase(15);
        pending_reqs.push_back(make_req(OP_LIST, '0, 0, 0));
        wait_idle();
        write_buckets(5'd0);
        random_phase(10);
        wait_idle();
        write_buckets(5'd31);  // saturates, entries kept from old count
        random_phase(15);
        pending_reqs.push_back(make_req(OP_LIST, '0, 0, 0));
        wait_idle();
        write_buckets(5'd7);
        random_phase(15);
        wait_idle();
        write_buckets(5'd16);
        random_phase(15);
        pending_reqs.push_back(make_req(OP_LIST, '0, 0, 0));
        wait_idle();

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/chte_pkg.sv
hw/rtl/chte_if.sv
hw/rtl/chte_bucket.sv
hw/rtl/chained_hash_table_engine.sv
verif/chte_tb_if.sv
verif/chained_hash_table_engine_tb.sv
